/* rtl/kmp_pkg.sv */
`timescale 1ns / 1ps
// kmp_pkg: shared types for the KMP pattern match counter.
// Controller state encoding and the command/status bundles between ctrl and datapath.
package kmp_pkg;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_LDCHK = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_FBK   = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic cap;        // capture the input transaction
        logic restart;    // drop the ready pattern, start a new load
        logic st_wr;      // write pattern byte at current length
        logic fb_wr;      // write fallback entry at current length
        logic fb_inc;     // fallback data is p+1, else zero
        logic len_inc;
        logic p_inc;
        logic p_ld;       // prefix pointer takes the fallback read data
        logic st_rd_p;    // read pattern byte at prefix pointer
        logic st_rd_fb;   // read pattern byte at fallback read data
        logic fb_rd_pm1;  // read fallback entry p-1
        logic fb_rd_lm1;  // full match: read fallback entry len-1, bump count
        logic finish;     // load complete
        logic emit;       // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic act;
        logic rdy;
        logic last;
        logic len_zero;
        logic len_full;
        logic eq;
        logic p_zero;
        logic last_hit;
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/kmp_pattern_match_counter.sv */
`timescale 1ns / 1ps
// kmp_pattern_match_counter: top level, KMP occurrence counter over a byte stream.
// Depends on kmp_pkg, kmp_ctrl, kmp_dp (which uses kmp_ram).
//
// Load the pattern one byte per transaction (action 0), flagging the final byte; up to
// MAX_PATTERN bytes are kept and the rest dropped. The fallback table is built on the fly
// as each pattern byte arrives, and the flagged byte makes the pattern ready and clears the
// match state and count. Each text byte (action 1) gives one result: whether an occurrence
// ends there, overlaps included, and the saturating count since the last load. A text byte
// with no ready pattern gives match_end 0 and the current count. One transaction is worked
// on at a time: a text byte goes through dispatch, the compare/fallback loop (skipped with
// no ready pattern) and emit, where it waits while the previous result is still held in
// the result register; a pattern byte goes through dispatch, a length check and the same
// loop (skipped for the first or a dropped byte), then finish for the flagged byte. KMP
// bounds the fallback steps by the earlier advances. Each step of the compare/fallback
// loop is one registered read of the pattern or fallback memory. The result register
// lets the next transaction in while a result waits.
module kmp_pattern_match_counter #(
    parameter int MAX_PATTERN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_symbol,
    input  logic        i_last_pattern_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_match_end,
    output logic [31:0] o_match_count
);
    import kmp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kmp_dp #(.MAX_PATTERN(MAX_PATTERN)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_action            (i_action),
        .i_symbol            (i_symbol),
        .i_last_pattern_byte (i_last_pattern_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_match_end         (o_match_end),
        .o_match_count       (o_match_count)
    );
endmodule

/* rtl/kmp_ram.sv */
`timescale 1ns / 1ps
// kmp_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/kmp_ctrl.sv */
`timescale 1ns / 1ps
// kmp_ctrl: sequencer for pattern load, fallback table build and text matching.
// Depends on kmp_pkg.
module kmp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  kmp_pkg::t_dp_sts i_sts,
    output kmp_pkg::t_dp_cmd o_cmd
);
    import kmp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;
    t_state  load_done;

    assign load_done  = i_sts.last ? S_FIN : S_IDLE;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.act) begin
                    if (i_sts.rdy) begin
                        cmd.st_rd_p = 1'b1;
                        n_state     = S_CMP;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    cmd.restart = i_sts.rdy;
                    n_state     = S_LDCHK;
                end
            end
            S_LDCHK: begin
                if (i_sts.len_full) begin
                    n_state = load_done;
                end else if (i_sts.len_zero) begin
                    cmd.st_wr   = 1'b1;
                    cmd.fb_wr   = 1'b1;
                    cmd.len_inc = 1'b1;
                    n_state     = load_done;
                end else begin
                    // new byte goes to store[len]; compare runs against store[k], k < len
                    cmd.st_wr   = 1'b1;
                    cmd.st_rd_p = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.act) begin
                    if (i_sts.eq && i_sts.last_hit) begin
                        cmd.fb_rd_lm1 = 1'b1;
                        n_state       = S_FBK;
                    end else if (i_sts.eq) begin
                        cmd.p_inc = 1'b1;
                        n_state   = S_EMIT;
                    end else if (!i_sts.p_zero) begin
                        cmd.fb_rd_pm1 = 1'b1;
                        n_state       = S_FBK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    if (i_sts.eq) begin
                        cmd.fb_wr   = 1'b1;
                        cmd.fb_inc  = 1'b1;
                        cmd.p_inc   = 1'b1;
                        cmd.len_inc = 1'b1;
                        n_state     = load_done;
                    end else if (!i_sts.p_zero) begin
                        cmd.fb_rd_pm1 = 1'b1;
                        n_state       = S_FBK;
                    end else begin
                        cmd.fb_wr   = 1'b1;
                        cmd.len_inc = 1'b1;
                        n_state     = load_done;
                    end
                end
            end
            S_FBK: begin
                cmd.p_ld = 1'b1;
                if (i_sts.act && i_sts.hit) begin
                    n_state = S_EMIT;
                end else begin
                    cmd.st_rd_fb = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* rtl/kmp_dp.sv */
`timescale 1ns / 1ps
// kmp_dp: datapath with pattern store, fallback table, prefix pointer, count, result register.
// Depends on kmp_pkg and kmp_ram.
module kmp_dp #(
    parameter int MAX_PATTERN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kmp_pkg::t_dp_cmd i_cmd,
    output kmp_pkg::t_dp_sts o_sts,
    input  logic             i_action,
    input  logic [7:0]       i_symbol,
    input  logic             i_last_pattern_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_match_end,
    output logic [31:0]      o_match_count
);
    import kmp_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic          r_act, r_last, r_hit, r_rdy, r_out_valid, r_out_match;
    logic [7:0]    r_sym;
    logic [LW-1:0] r_len, r_p;
    logic [31:0]   r_cnt, r_out_count;

    logic          n_hit, n_rdy, n_out_valid;
    logic [LW-1:0] n_len, n_p;
    logic [31:0]   n_cnt;

    logic [LW-1:0] p_plus1, p_m1, len_m1;
    logic [7:0]    st_rdata;
    logic [IW-1:0] fb_rdata, st_raddr, fb_raddr, fb_wdata;
    logic          out_free;

    assign p_plus1  = r_p + LW'(1);
    assign p_m1     = r_p - LW'(1);
    assign len_m1   = r_len - LW'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    assign st_raddr = i_cmd.st_rd_fb ? fb_rdata : r_p[IW-1:0];
    assign fb_raddr = i_cmd.fb_rd_lm1 ? len_m1[IW-1:0] : p_m1[IW-1:0];
    assign fb_wdata = i_cmd.fb_inc ? p_plus1[IW-1:0] : '0;

    kmp_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat (
        .i_clk   (i_clk),
        .i_we    (i_cmd.st_wr),
        .i_waddr (r_len[IW-1:0]),
        .i_wdata (r_sym),
        .i_re    (i_cmd.st_rd_p | i_cmd.st_rd_fb),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    kmp_ram #(.WIDTH(IW), .DEPTH(MAX_PATTERN)) u_fb (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fb_wr),
        .i_waddr (r_len[IW-1:0]),
        .i_wdata (fb_wdata),
        .i_re    (i_cmd.fb_rd_pm1 | i_cmd.fb_rd_lm1),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    always_comb begin
        n_p = r_p;
        if (i_cmd.restart || i_cmd.finish) begin
            n_p = '0;
        end else if (i_cmd.p_ld) begin
            n_p = LW'(fb_rdata);
        end else if (i_cmd.p_inc) begin
            n_p = p_plus1;
        end

        n_len = r_len;
        if (i_cmd.restart) begin
            n_len = '0;
        end else if (i_cmd.len_inc) begin
            n_len = r_len + LW'(1);
        end

        n_rdy = r_rdy;
        if (i_cmd.restart) begin
            n_rdy = 1'b0;
        end else if (i_cmd.finish) begin
            n_rdy = 1'b1;
        end

        n_cnt = r_cnt;
        if (i_cmd.finish) begin
            n_cnt = '0;
        end else if (i_cmd.fb_rd_lm1 && (r_cnt != '1)) begin
            n_cnt = r_cnt + 32'd1;
        end

        n_hit = r_hit;
        if (i_cmd.cap) begin
            n_hit = 1'b0;
        end else if (i_cmd.fb_rd_lm1) begin
            n_hit = 1'b1;
        end

        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_p         <= '0;
            r_rdy       <= 1'b0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_p         <= n_p;
            r_rdy       <= n_rdy;
            r_cnt       <= n_cnt;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_act  <= i_action;
            r_sym  <= i_symbol;
            r_last <= i_last_pattern_byte;
        end
        if (i_cmd.emit) begin
            r_out_match <= r_hit;
            r_out_count <= r_cnt;
        end
    end

    assign o_sts.act      = r_act;
    assign o_sts.rdy      = r_rdy;
    assign o_sts.last     = r_last;
    assign o_sts.len_zero = (r_len == '0);
    assign o_sts.len_full = (r_len == LW'(MAX_PATTERN));
    assign o_sts.eq       = (st_rdata == r_sym);
    assign o_sts.p_zero   = (r_p == '0);
    assign o_sts.last_hit = (p_plus1 == r_len);
    assign o_sts.hit      = r_hit;
    assign o_sts.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_match_end   = r_out_match;
    assign o_match_count = r_out_count;
endmodule

/* rtl/kmp_checker.sv */
`timescale 1ns / 1ps
// kmp_checker: port-level assertions for kmp_pattern_match_counter, bound to the top level.
// No dependencies.
module kmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_match_end,
    input logic [31:0] o_match_count
);
    // one transaction at a time: an accepted input blocks the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on back-to-back cycles");

    // a reported occurrence means the count is nonzero
    a_match_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_match_end) |-> (o_match_count != 32'd0))
        else $error("match reported with zero count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_match_end) && $stable(o_match_count)))
        else $error("result changed while stalled");
endmodule

bind kmp_pattern_match_counter kmp_checker u_kmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_match_end   (o_match_end),
    .o_match_count (o_match_count)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for kmp_pattern_match_counter, with directed and random traffic.
// Depends only on the RTL; a built-in KMP predictor checks every match report in order.
module tb_top;

    localparam int MAX_PATTERN    = 64;
    localparam bit ACT_LOAD       = 1'b0;
    localparam bit ACT_TEXT       = 1'b1;
    localparam int TARGET_ITEMS   = 1100;
    localparam int TAIL_ITEMS     = 150;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int HOLD_OFF_AT    = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;

    typedef struct {
        bit       act;
        bit [7:0] sym;
        bit       flag;
    } t_feed_item;

    typedef struct {
        bit        hit;
        bit [31:0] count;
    } t_match_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_action = 1'b0;
    logic [7:0]  i_symbol = 8'h00;
    logic        i_last_pattern_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_match_end;
    logic [31:0] o_match_count;

    kmp_pattern_match_counter #(
        .MAX_PATTERN (MAX_PATTERN)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_action            (i_action),
        .i_symbol            (i_symbol),
        .i_last_pattern_byte (i_last_pattern_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_match_end         (o_match_end),
        .o_match_count       (o_match_count)
    );

    // stimulus and expected match reports
    t_feed_item    symbol_feed_q[$];
    t_match_report due_reports_q[$];

    // predictor copy of the matcher
    bit [7:0]  pat_mem[MAX_PATTERN];
    bit [5:0]  fail_tab[MAX_PATTERN];
    int        pat_len = 0;
    bit        pat_ready = 1'b0;
    int        prefix_len = 0;
    bit [31:0] occ_count = 32'd0;

    int            mismatches = 0;
    int            reports_checked = 0;
    int            items_sent = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    logic          out_holding = 1'b0;
    logic          tail_phase = 1'b0;
    int            idle_cycles = 0;
    t_feed_item    next_item;
    t_match_report want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the predictor by one accepted transaction; text bytes queue a report.
    function automatic void absorb_item(bit act, bit [7:0] sym, bit flag);
        int            j;
        int            k;
        int            pos;
        bit            hit;
        t_match_report rep;
        if (act == ACT_LOAD) begin
            if (pat_ready) begin
                pat_ready = 1'b0;
                pat_len   = 0;
            end
            if (pat_len < MAX_PATTERN) begin
                pat_mem[pat_len] = sym;
                pat_len++;
            end
            if (flag && pat_len > 0) begin
                // longest proper prefix-suffix table
                k = 0;
                pos = 1;
                fail_tab[0] = '0;
                while (pos < pat_len) begin
                    if (pat_mem[pos] == pat_mem[k]) begin
                        k++;
                        fail_tab[pos] = k[5:0];
                        pos++;
                    end else if (k != 0) begin
                        k = int'(fail_tab[k-1]);
                    end else begin
                        fail_tab[pos] = '0;
                        pos++;
                    end
                end
                prefix_len = 0;
                occ_count  = 32'd0;
                pat_ready  = 1'b1;
            end
        end else begin
            hit = 1'b0;
            if (pat_ready && pat_len > 0) begin
                j = prefix_len;
                if (j >= pat_len)
                    j = 0;
                while (j > 0 && pat_mem[j] != sym)
                    j = int'(fail_tab[j-1]);
                if (pat_mem[j] == sym)
                    j++;
                if (j == pat_len) begin
                    hit = 1'b1;
                    if (occ_count != 32'hFFFF_FFFF)
                        occ_count++;
                    j = int'(fail_tab[j-1]);
                end
                prefix_len = j;
            end
            rep.hit   = hit;
            rep.count = occ_count;
            due_reports_q.push_back(rep);
        end
    endfunction

    task automatic add_item(input bit act, input bit [7:0] sym, input bit flag);
        t_feed_item it;
        it.act  = act;
        it.sym  = sym;
        it.flag = flag;
        symbol_feed_q.push_back(it);
    endtask

    task automatic plan_directed();
        // text before any pattern exists
        add_item(ACT_TEXT, 8'h00, 1'b0);
        add_item(ACT_TEXT, 8'hFF, 1'b1);
        // single-byte pattern
        add_item(ACT_LOAD, 8'hFF, 1'b1);
        add_item(ACT_TEXT, 8'hFF, 1'b0);
        add_item(ACT_TEXT, 8'hFF, 1'b0);
        add_item(ACT_TEXT, 8'h00, 1'b0);
        // new load after a ready pattern, with text in the middle of the load
        add_item(ACT_LOAD, 8'h00, 1'b0);
        add_item(ACT_TEXT, 8'h00, 1'b0);
        add_item(ACT_LOAD, 8'h00, 1'b1);
        add_item(ACT_TEXT, 8'h00, 1'b0);
        add_item(ACT_TEXT, 8'h00, 1'b1);
        add_item(ACT_TEXT, 8'h00, 1'b0);
        // fallback on mismatch: pattern AAB against AAAB
        add_item(ACT_LOAD, 8'h41, 1'b0);
        add_item(ACT_LOAD, 8'h41, 1'b0);
        add_item(ACT_LOAD, 8'h42, 1'b1);
        add_item(ACT_TEXT, 8'h41, 1'b0);
        add_item(ACT_TEXT, 8'h41, 1'b0);
        add_item(ACT_TEXT, 8'h41, 1'b0);
        add_item(ACT_TEXT, 8'h42, 1'b0);
        add_item(ACT_TEXT, 8'h41, 1'b0);
        add_item(ACT_LOAD, 8'h80, 1'b1);
        add_item(ACT_TEXT, 8'h7F, 1'b0);
        add_item(ACT_TEXT, 8'h80, 1'b0);
    endtask

    task automatic plan_random_traffic();
        bit [7:0] alpha[3];
        bit [7:0] pat[$];
        int       n_alpha;
        int       pat_n;
        int       text_n;
        int       emitted;
        int       kind;
        int       pick;
        int       i;
        while (symbol_feed_q.size() < TARGET_ITEMS) begin
            kind    = $urandom_range(0, 99);
            n_alpha = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 2;
            for (i = 0; i < 3; i++)
                alpha[i] = 8'($urandom_range(0, 255));
            if (kind < 80) begin
                // well-formed: load a pattern over a small alphabet, then scan text
                pick = $urandom_range(0, 99);
                if (pick < 88)
                    pat_n = $urandom_range(1, 10);
                else if (pick < 97)
                    pat_n = $urandom_range(11, MAX_PATTERN);
                else
                    pat_n = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 16);
                pat.delete();
                for (i = 0; i < pat_n; i++) begin
                    pat.push_back(alpha[$urandom_range(0, n_alpha - 1)]);
                    if ($urandom_range(0, 39) == 0)
                        add_item(ACT_TEXT, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
                    add_item(ACT_LOAD, pat[i], i == pat_n - 1);
                end
                text_n  = $urandom_range(10, 60);
                emitted = 0;
                while (emitted < text_n) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 6) begin
                        for (i = 0; i < pat.size() && i < MAX_PATTERN; i++)
                            add_item(ACT_TEXT, pat[i], 1'($urandom_range(0, 1)));
                        emitted += i;
                    end else if (pick < 17) begin
                        add_item(ACT_TEXT, alpha[$urandom_range(0, n_alpha - 1)],
                                 1'($urandom_range(0, 1)));
                        emitted++;
                    end else begin
                        add_item(ACT_TEXT, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
                        emitted++;
                    end
                end
            end else if (kind < 90) begin
                // broken: unfinished load, then text with no ready pattern
                pat_n = $urandom_range(1, 6);
                for (i = 0; i < pat_n; i++)
                    add_item(ACT_LOAD, 8'($urandom_range(0, 255)), 1'b0);
                text_n = $urandom_range(1, 8);
                for (i = 0; i < text_n; i++)
                    add_item(ACT_TEXT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                text_n = $urandom_range(5, 20);
                for (i = 0; i < text_n; i++)
                    add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        plan_directed();
        plan_random_traffic();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (symbol_feed_q.size() > 0 || i_in_valid || due_reports_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid          <= 1'b0;
            i_action            <= 1'b0;
            i_symbol            <= 8'h00;
            i_last_pattern_byte <= 1'b0;
            tail_phase          <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                absorb_item(i_action, i_symbol, i_last_pattern_byte);
                items_sent++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                // idle bursts, except in quiet stretches, the tail and the hold-off
                if (gap_left == 0 && !tail_phase && !out_holding
                        && (items_sent / 100) % 4 != 1 && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 17);
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (symbol_feed_q.size() > 0) begin
                    next_item = symbol_feed_q.pop_front();
                    i_in_valid          <= 1'b1;
                    i_action            <= next_item.act;
                    i_symbol            <= next_item.sym;
                    i_last_pattern_byte <= next_item.flag;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            tail_phase <= (symbol_feed_q.size() < TAIL_ITEMS);
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_holding <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_reports_q.size() == 0) begin
                    $display("%0t: unexpected transaction, match_end %0d count %0d",
                             $time, o_match_end, o_match_count);
                    mismatches++;
                end else begin
                    want = due_reports_q.pop_front();
                    if (o_match_end !== want.hit) begin
                        $display("%0t: match_end mismatch, expected %0d actual %0d",
                                 $time, want.hit, o_match_end);
                        mismatches++;
                    end
                    if (o_match_count !== want.count) begin
                        $display("%0t: match_count mismatch, expected %0d actual %0d",
                                 $time, want.count, o_match_count);
                        mismatches++;
                    end
                    reports_checked++;
                end
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && reports_checked >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            if (stall_left == 0 && !tail_phase && (reports_checked / 100) % 4 != 3
                    && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 17);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (tail_phase) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
            out_holding <= (hold_left > 0);
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* files.f */
rtl/kmp_pkg.sv
rtl/kmp_ram.sv
rtl/kmp_ctrl.sv
rtl/kmp_dp.sv
rtl/kmp_pattern_match_counter.sv
rtl/kmp_checker.sv
verif/tb_top.sv
